// ----- hw/rtl/bsfn_pkg.sv -----
// ---------------------------------------------------------------------------
// bsfn_pkg: shared definitions for the bit set with forward search
// Command codes, field widths and the lowest-set-bit encoder.
// ---------------------------------------------------------------------------
package bsfn_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 10;
    localparam int FOUND_W   = 11;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [WORD_BITS-1:0] word_t;

    localparam cmd_t CMD_CONTAINS   = 3'd0;
    localparam cmd_t CMD_INSERT     = 3'd1;
    localparam cmd_t CMD_ERASE      = 3'd2;
    localparam cmd_t CMD_CLEAR      = 3'd3;
    localparam cmd_t CMD_FIND_NEXT  = 3'd4;
    localparam cmd_t CMD_FIND_FIRST = 3'd5;

    // Position of the lowest set bit, found by halving the word six times.
    function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
        word_t            v;
        word_t            mask;
        logic [BIT_W-1:0] p;
        v = w;
        p = '0;
        for (int l = BIT_W - 1; l >= 0; l--)
        begin
            mask = (word_t'(1) << (1 << l)) - word_t'(1);
            if ((v & mask) == '0)
            begin
                p[l] = 1'b1;
                v    = v >> (1 << l);
            end
        end
        return p;
    endfunction

endpackage

// ----- hw/rtl/bsfn_ram.sv -----
// ---------------------------------------------------------------------------
// bsfn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents not reset.
// ---------------------------------------------------------------------------
module bsfn_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/bitmap_set_with_find_next.sv -----
// ---------------------------------------------------------------------------
// bitmap_set_with_find_next: fixed-capacity bit set with forward search
// Bits live in 64-bit words of one RAM; bit commands read-modify-write a
// word, find commands scan words from the start word upward.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                      tuser
//  s_axis   in   [9:0] index                [2:0] command
//  m_axis   out  [10:0] found_index         [0] hit
//
//  Contains/insert/erase: the word is read on accept, updated in ST_MOD
//  (contains leaves it) and the result passed to ST_OUT. Find: the scan
//  reads one RAM word per cycle from the start word upward and stops at
//  the first set bit, or after the last word when none is found.
//  Clear all: one word written per cycle.
//  After reset a clearing pass over all words runs with s_axis_tready
//  low. One item is in flight at a time; the result beat waits in an output
//  register, and a stalled result only holds back the following item.
// ---------------------------------------------------------------------------
module bitmap_set_with_find_next
    import bsfn_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] index
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [10:0] found_index
    output logic        m_axis_tuser    // [0] hit
);

    localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PW        = (AW + 7 > FOUND_W) ? AW + 7 : FOUND_W;

    localparam logic [AW:0]      NW_C      = (AW + 1)'(NUM_WORDS);
    localparam logic [AW-1:0]    LAST_W    = AW'(NUM_WORDS - 1);
    localparam logic [PW-1:0]    CAP_C     = PW'(CAPACITY);
    localparam logic [FOUND_W-1:0] CAP_FOUND = FOUND_W'(CAPACITY);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // Control registers
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_res_reg, clr_res_next;
    logic          chk_pend_reg, chk_pend_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers
    cmd_t             cmd_reg, cmd_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW:0]      scan_w_reg, scan_w_next;
    logic             scan_first_reg, scan_first_next;
    logic [AW-1:0]    chk_w_reg, chk_w_next;
    logic             chk_first_reg, chk_first_next;
    logic [BIT_W-1:0] start_bit_reg, start_bit_next;
    logic             res_hit_reg, res_hit_next;
    logic [FOUND_W-1:0] res_found_reg, res_found_next;
    logic             out_hit_reg, out_hit_next;
    logic [FOUND_W-1:0] out_found_reg, out_found_next;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    word_t         ram_rdata;

    // Decoded input beat
    cmd_t             in_cmd;
    logic [IDX_W-1:0] in_idx;
    logic             in_accept;
    logic             idx_in_range;
    logic [FOUND_W-1:0] start_pos;
    logic             start_in_range;

    // Scan datapath
    word_t            block;
    logic [PW-1:0]    pos;
    logic             issue;

    assign in_cmd         = s_axis_tuser;
    assign in_idx         = s_axis_tdata[IDX_W-1:0];
    assign s_axis_tready  = (state_reg == ST_IDLE);
    assign in_accept      = s_axis_tvalid && s_axis_tready;
    assign idx_in_range   = PW'(in_idx) < CAP_C;
    assign start_pos      = (in_cmd == CMD_FIND_FIRST) ? '0
                          : FOUND_W'({1'b0, in_idx} + 11'd1);
    assign start_in_range = PW'(start_pos) < CAP_C;

    // Mask the start word below the start bit and locate the lowest set bit
    assign block = ram_rdata & (chk_first_reg ? (~word_t'(0) << start_bit_reg) : ~word_t'(0));
    assign pos   = PW'({chk_w_reg, lowest_set(block)});
    assign issue = scan_w_reg < NW_C;

    bsfn_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_res_next    = clr_res_reg;
        chk_pend_next   = chk_pend_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        bit_next        = bit_reg;
        addr_next       = addr_reg;
        scan_w_next     = scan_w_reg;
        scan_first_next = scan_first_reg;
        chk_w_next      = chk_w_reg;
        chk_first_next  = chk_first_reg;
        start_bit_next  = start_bit_reg;
        res_hit_next    = res_hit_reg;
        res_found_next  = res_found_reg;
        out_hit_next    = out_hit_reg;
        out_found_next  = out_found_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = addr_reg;

        // Drop the result beat once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_W)
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_res_reg ? ST_OUT : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                ram_raddr = AW'(in_idx[IDX_W-1:BIT_W]);
                if (in_accept)
                begin
                    cmd_next       = in_cmd;
                    bit_next       = in_idx[BIT_W-1:0];
                    addr_next      = AW'(in_idx[IDX_W-1:BIT_W]);
                    res_hit_next   = 1'b0;
                    res_found_next = '0;
                    unique case (in_cmd) inside
                        CMD_CONTAINS, CMD_INSERT, CMD_ERASE:
                        begin
                            state_next = idx_in_range ? ST_MOD : ST_OUT;
                        end
                        CMD_CLEAR:
                        begin
                            clr_res_next = 1'b1;
                            clr_cnt_next = '0;
                            state_next   = ST_CLR;
                        end
                        CMD_FIND_NEXT, CMD_FIND_FIRST:
                        begin
                            res_found_next  = CAP_FOUND;
                            scan_w_next     = (AW + 1)'(start_pos[FOUND_W-1:BIT_W]);
                            start_bit_next  = start_pos[BIT_W-1:0];
                            scan_first_next = 1'b1;
                            chk_pend_next   = 1'b0;
                            state_next      = start_in_range ? ST_SCAN : ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_MOD:
            begin
                ram_waddr          = addr_reg;
                ram_wdata          = ram_rdata;
                ram_wdata[bit_reg] = (cmd_reg == CMD_INSERT);
                ram_we             = (cmd_reg != CMD_CONTAINS);
                res_hit_next       = (cmd_reg == CMD_INSERT) ? !ram_rdata[bit_reg]
                                                             : ram_rdata[bit_reg];
                state_next         = ST_OUT;
            end

            ST_SCAN:
            begin
                ram_raddr = scan_w_reg[AW-1:0];
                if (chk_pend_reg && (block != '0))
                begin
                    res_hit_next   = pos < CAP_C;
                    res_found_next = (pos < CAP_C) ? pos[FOUND_W-1:0] : CAP_FOUND;
                    chk_pend_next  = 1'b0;
                    state_next     = ST_OUT;
                end
                else if (issue)
                begin
                    chk_pend_next   = 1'b1;
                    chk_w_next      = scan_w_reg[AW-1:0];
                    chk_first_next  = scan_first_reg;
                    scan_first_next = 1'b0;
                    scan_w_next     = scan_w_reg + (AW + 1)'(1);
                end
                else if (chk_pend_reg)
                begin
                    chk_pend_next = 1'b0;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_found_next = res_found_reg;
                    clr_res_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            clr_res_reg   <= 1'b0;
            chk_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_res_reg   <= clr_res_next;
            chk_pend_reg  <= chk_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        bit_reg        <= bit_next;
        addr_reg       <= addr_next;
        scan_w_reg     <= scan_w_next;
        scan_first_reg <= scan_first_next;
        chk_w_reg      <= chk_w_next;
        chk_first_reg  <= chk_first_next;
        start_bit_reg  <= start_bit_next;
        res_hit_reg    <= res_hit_next;
        res_found_reg  <= res_found_next;
        out_hit_reg    <= out_hit_next;
        out_found_reg  <= out_found_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {{(16 - FOUND_W){1'b0}}, out_found_reg};

`ifndef SYNTHESIS
    // An in-range bit command goes straight to the modify cycle
    a_bit_cmd_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && idx_in_range && (in_cmd == CMD_CONTAINS || in_cmd == CMD_INSERT
            || in_cmd == CMD_ERASE)) |=> (state_reg == ST_MOD))
        else $error("bit command did not enter modify cycle");

    // A scan never writes the store
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("store written during scan");

    // A result beat appears only from the output stage
    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result beat without output stage");

    // No input is taken while a result is still being formed
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_MOD) |=> !$past(in_accept))
        else $error("input accepted during processing");
`endif

endmodule
